[rtl/wpcr_pkg.sv]
package wpcr_pkg;

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 1024;

	localparam int unsigned LEN_W      = 24;
	localparam int unsigned COL_W      = 12;
	localparam int unsigned WIDTH_W    = 13;
	localparam int unsigned HEIGHT_W   = 11;
	localparam int unsigned ROW_W      = 10;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned PROD_W     = SAMPLE_W + HEIGHT_W;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned DIV_STEPS  = LEN_W;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIXTEEN_BIT  = 3'd4;

	localparam int unsigned RST_SAMPLE_COUNT = 1024;
	localparam int unsigned RST_WIDTH        = 512;
	localparam int unsigned RST_HEIGHT       = 128;
	localparam int unsigned RST_QUOT         = RST_SAMPLE_COUNT / RST_WIDTH;
	localparam int unsigned RST_RMD          = RST_SAMPLE_COUNT % RST_WIDTH;
	localparam int unsigned RST_END          = (RST_QUOT > RST_SAMPLE_COUNT - 1) ?
	                                           RST_SAMPLE_COUNT - 1 : RST_QUOT;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	typedef struct packed {
		logic [ROW_W-1:0] first;
		logic [ROW_W-1:0] last;
		logic             lit;
	} band_t;

endpackage

[rtl/waveform_peak_column_render_core.sv]
// Channel | Signals                                  | Direction
// cfg     | cfg_valid cfg_ready cfg_index cfg_data   | in: register write
// in      | in_valid in_ready sample_left/right      | in: one audio frame per transfer
// out     | out_valid out_ready column .. last_column| out: one closed column per transfer
//
// One frame per cycle unless busy or a closing frame finds stage 1 full; a column
// result is registered in stage 1 and then stage 2. Rate is set by the per-frame
// min/max update and the column-end compare. A write to a defined register starts
// a 24-step restoring divide (len / width), with in_ready and cfg_ready low while busy.
// Reset loads the default registers and their precomputed column step.
// A stalled output fills the two result stages; frames that close no column
// are still taken while they are full.
module waveform_peak_column_render_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [wpcr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wpcr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [wpcr_pkg::SAMPLE_W-1:0]  sample_left,
	input  logic signed [wpcr_pkg::SAMPLE_W-1:0]  sample_right,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [wpcr_pkg::COL_W-1:0]            column,
	output logic [wpcr_pkg::ROW_W-1:0]            top_first_row,
	output logic [wpcr_pkg::ROW_W-1:0]            top_last_row,
	output logic                                  top_lit,
	output logic [wpcr_pkg::ROW_W-1:0]            bottom_first_row,
	output logic [wpcr_pkg::ROW_W-1:0]            bottom_last_row,
	output logic                                  bottom_lit,
	output logic                                  last_column
);

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_LOAD,
		DIV_RUN,
		DIV_FINISH
	} div_state_t;

	localparam int unsigned LW = wpcr_pkg::LEN_W;
	localparam int unsigned WW = wpcr_pkg::WIDTH_W;
	localparam int unsigned HW = wpcr_pkg::HEIGHT_W;
	localparam int unsigned CW = wpcr_pkg::COL_W;
	localparam int unsigned RW = wpcr_pkg::ROW_W;
	localparam int unsigned PW = wpcr_pkg::PROD_W;

	function automatic wpcr_pkg::band_t scan_band(
		input wpcr_pkg::sample_t mn,
		input wpcr_pkg::sample_t mx,
		input logic [HW-1:0]     div,
		input logic [HW-1:0]     count,
		input logic [HW-1:0]     offset
	);
		logic [wpcr_pkg::SAMPLE_W-1:0] a;
		logic [wpcr_pkg::SAMPLE_W-1:0] b;
		logic [PW-1:0]                 lo_p;
		logic [PW-1:0]                 hi_p;
		logic [PW-1:0]                 hi_m1;
		logic [HW-1:0]                 kmin;
		logic [HW-1:0]                 kmax;
		logic [HW-1:0]                 kmax_c;
		logic [HW-1:0]                 cnt_m1;
		logic [HW-1:0]                 first;
		logic [HW-1:0]                 last;
		wpcr_pkg::band_t               r;
		// offset-binary level: row k lit iff a*div < k*65536 < b*div
		a      = {~mn[wpcr_pkg::SAMPLE_W-1], mn[wpcr_pkg::SAMPLE_W-2:0]};
		b      = {~mx[wpcr_pkg::SAMPLE_W-1], mx[wpcr_pkg::SAMPLE_W-2:0]};
		lo_p   = PW'(a) * PW'(div);
		hi_p   = PW'(b) * PW'(div);
		hi_m1  = hi_p - PW'(1);
		kmin   = HW'(lo_p >> 16) + HW'(1);
		kmax   = HW'(hi_m1 >> 16);
		cnt_m1 = count - HW'(1);
		kmax_c = (kmax < cnt_m1) ? kmax : cnt_m1;
		r.lit  = (hi_p != '0) && (kmin <= kmax_c);
		first  = offset + kmin;
		last   = offset + kmax_c;
		r.first = r.lit ? first[RW-1:0] : '0;
		r.last  = r.lit ? last[RW-1:0] : '0;
		return r;
	endfunction

	// configuration
	logic [LW-1:0] sample_count_q;
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic          stereo_q;
	logic          sixteen_bit_q;

	logic [WW-1:0] eff_w;
	logic [LW-1:0] eff_len;
	logic [LW-1:0] len_m1;
	logic [HW-1:0] eff_h;
	logic [HW-1:0] half_h;

	// divider
	div_state_t                       div_state_q;
	logic [wpcr_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic [LW-1:0]                    div_num_q;
	logic [WW-1:0]                    div_rem_q;
	logic [WW-1:0]                    div_shift;
	logic                             div_ge;
	logic [LW-1:0]                    quot_q;
	logic [CW-1:0]                    rmd_q;
	logic                             busy;
	logic                             cfg_hit;
	logic                             cfg_fire;

	// column tracking
	logic [LW-1:0]     frame_q;
	logic [CW-1:0]     column_q;
	logic [LW-1:0]     end_raw_q;
	logic [LW-1:0]     end_q;
	logic [CW-1:0]     rem_q;
	logic              pending_q;
	wpcr_pkg::sample_t min_l_q;
	wpcr_pkg::sample_t max_l_q;
	wpcr_pkg::sample_t min_r_q;
	wpcr_pkg::sample_t max_r_q;

	wpcr_pkg::sample_t lvl_l;
	wpcr_pkg::sample_t lvl_r;
	wpcr_pkg::sample_t nmin_l;
	wpcr_pkg::sample_t nmax_l;
	wpcr_pkg::sample_t nmin_r;
	wpcr_pkg::sample_t nmax_r;
	logic              at_end;
	logic              emit_now;
	logic              col_last;
	logic [WW-1:0]     sum_rem;
	logic              carry;
	logic [CW-1:0]     rem_next;
	logic [LW-1:0]     end_raw_next;
	logic [LW-1:0]     end_next;
	logic [LW-1:0]     quot_clamp;
	logic [LW-1:0]     div_clamp;
	logic              in_fire;

	// result stages
	logic              v_s1;
	logic [CW-1:0]     col_s1;
	logic              last_s1;
	wpcr_pkg::sample_t min_l_s1;
	wpcr_pkg::sample_t max_l_s1;
	wpcr_pkg::sample_t min_r_s1;
	wpcr_pkg::sample_t max_r_s1;
	logic              s1_adv;
	logic              s1_free;

	logic              v_s2;
	logic [CW-1:0]     col_s2;
	logic              last_s2;
	wpcr_pkg::band_t   top_s2;
	wpcr_pkg::band_t   bot_s2;
	wpcr_pkg::band_t   top_band;
	wpcr_pkg::band_t   bot_band;

	// effective register values
	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (width_q > WW'(wpcr_pkg::MAX_WIDTH)) begin
			eff_w = WW'(wpcr_pkg::MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		eff_len = (sample_count_q < LW'(eff_w)) ? LW'(eff_w) : sample_count_q;
		len_m1  = eff_len - LW'(1);
		if (height_q < HW'(2)) begin
			eff_h = HW'(2);
		end else if (height_q > HW'(wpcr_pkg::MAX_HEIGHT)) begin
			eff_h = HW'(wpcr_pkg::MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
		half_h = eff_h >> 1;
	end

	assign busy      = (div_state_q != DIV_IDLE);
	assign cfg_ready = !busy;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_comb begin
		case (cfg_index)
			wpcr_pkg::REG_SAMPLE_COUNT,
			wpcr_pkg::REG_WIDTH,
			wpcr_pkg::REG_HEIGHT,
			wpcr_pkg::REG_STEREO,
			wpcr_pkg::REG_SIXTEEN_BIT: cfg_hit = 1'b1;
			default:                   cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= LW'(wpcr_pkg::RST_SAMPLE_COUNT);
			width_q        <= WW'(wpcr_pkg::RST_WIDTH);
			height_q       <= HW'(wpcr_pkg::RST_HEIGHT);
			stereo_q       <= 1'b0;
			sixteen_bit_q  <= 1'b1;
		end else if (cfg_fire) begin
			case (cfg_index)
				wpcr_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg_data[LW-1:0];
				wpcr_pkg::REG_WIDTH:        width_q        <= cfg_data[WW-1:0];
				wpcr_pkg::REG_HEIGHT:       height_q       <= cfg_data[HW-1:0];
				wpcr_pkg::REG_STEREO:       stereo_q       <= cfg_data[0];
				wpcr_pkg::REG_SIXTEEN_BIT:  sixteen_bit_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// restoring divide: eff_len / eff_w
	assign div_shift = {div_rem_q[WW-2:0], div_num_q[LW-1]};
	assign div_ge    = (div_shift >= eff_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_state_q <= DIV_IDLE;
			div_cnt_q   <= '0;
			div_num_q   <= '0;
			div_rem_q   <= '0;
			quot_q      <= LW'(wpcr_pkg::RST_QUOT);
			rmd_q       <= CW'(wpcr_pkg::RST_RMD);
		end else begin
			case (div_state_q)
				DIV_IDLE: begin
					if (cfg_fire && cfg_hit) begin
						div_state_q <= DIV_LOAD;
					end
				end
				DIV_LOAD: begin
					div_num_q   <= eff_len;
					div_rem_q   <= '0;
					div_cnt_q   <= '0;
					div_state_q <= DIV_RUN;
				end
				DIV_RUN: begin
					div_num_q <= {div_num_q[LW-2:0], div_ge};
					div_rem_q <= div_ge ? (div_shift - eff_w) : div_shift;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == wpcr_pkg::DIV_CNT_W'(wpcr_pkg::DIV_STEPS - 1)) begin
						div_state_q <= DIV_FINISH;
					end
				end
				DIV_FINISH: begin
					quot_q      <= div_num_q;
					rmd_q       <= div_rem_q[CW-1:0];
					div_state_q <= DIV_IDLE;
				end
				default: div_state_q <= DIV_IDLE;
			endcase
		end
	end

	// per-frame datapath
	always_comb begin
		lvl_l = sixteen_bit_q ? sample_left  : {sample_left[7:0], 8'h00};
		lvl_r = sixteen_bit_q ? sample_right : {sample_right[7:0], 8'h00};
		nmin_l = (lvl_l < min_l_q) ? lvl_l : min_l_q;
		nmax_l = (lvl_l > max_l_q) ? lvl_l : max_l_q;
		nmin_r = (lvl_r < min_r_q) ? lvl_r : min_r_q;
		nmax_r = (lvl_r > max_r_q) ? lvl_r : max_r_q;

		at_end   = (frame_q == end_q);
		emit_now = pending_q || at_end;
		col_last = (WW'(column_q) >= (eff_w - WW'(1)));

		sum_rem      = WW'(rem_q) + WW'(rmd_q);
		carry        = (sum_rem >= eff_w);
		rem_next     = carry ? CW'(sum_rem - eff_w) : CW'(sum_rem);
		end_raw_next = end_raw_q + quot_q + LW'(carry);
		end_next     = (end_raw_next > len_m1) ? len_m1 : end_raw_next;
		quot_clamp   = (quot_q > len_m1) ? len_m1 : quot_q;
		div_clamp    = (div_num_q > len_m1) ? len_m1 : div_num_q;
	end

	assign s1_adv   = !v_s2 || out_ready;
	assign s1_free  = !v_s1 || s1_adv;
	assign in_ready = !busy && (!emit_now || s1_free);
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= '0;
			column_q  <= '0;
			end_raw_q <= LW'(wpcr_pkg::RST_QUOT);
			end_q     <= LW'(wpcr_pkg::RST_END);
			rem_q     <= CW'(wpcr_pkg::RST_RMD);
			pending_q <= 1'b0;
			min_l_q   <= wpcr_pkg::SAMPLE_MAX;
			max_l_q   <= wpcr_pkg::SAMPLE_MIN;
			min_r_q   <= wpcr_pkg::SAMPLE_MAX;
			max_r_q   <= wpcr_pkg::SAMPLE_MIN;
		end else if (cfg_fire && cfg_hit) begin
			frame_q   <= '0;
			column_q  <= '0;
			pending_q <= 1'b0;
			min_l_q   <= wpcr_pkg::SAMPLE_MAX;
			max_l_q   <= wpcr_pkg::SAMPLE_MIN;
			min_r_q   <= wpcr_pkg::SAMPLE_MAX;
			max_r_q   <= wpcr_pkg::SAMPLE_MIN;
		end else if (div_state_q == DIV_FINISH) begin
			end_raw_q <= div_num_q;
			end_q     <= div_clamp;
			rem_q     <= div_rem_q[CW-1:0];
		end else if (in_fire) begin
			if (pending_q) begin
				// single-frame last column reported; this frame opens a new pass
				frame_q   <= LW'(1);
				column_q  <= '0;
				pending_q <= 1'b0;
				end_raw_q <= quot_q;
				end_q     <= quot_clamp;
				rem_q     <= rmd_q;
				min_l_q   <= lvl_l;
				max_l_q   <= lvl_l;
				min_r_q   <= lvl_r;
				max_r_q   <= lvl_r;
			end else if (at_end && col_last) begin
				frame_q   <= '0;
				column_q  <= '0;
				end_raw_q <= quot_q;
				end_q     <= quot_clamp;
				rem_q     <= rmd_q;
				min_l_q   <= wpcr_pkg::SAMPLE_MAX;
				max_l_q   <= wpcr_pkg::SAMPLE_MIN;
				min_r_q   <= wpcr_pkg::SAMPLE_MAX;
				max_r_q   <= wpcr_pkg::SAMPLE_MIN;
			end else if (at_end) begin
				// boundary frame seeds the next column
				column_q  <= column_q + 1'b1;
				end_raw_q <= end_raw_next;
				end_q     <= end_next;
				rem_q     <= rem_next;
				min_l_q   <= lvl_l;
				max_l_q   <= lvl_l;
				min_r_q   <= lvl_r;
				max_r_q   <= lvl_r;
				if (end_next <= frame_q) begin
					pending_q <= 1'b1;
				end else begin
					frame_q <= frame_q + 1'b1;
				end
			end else begin
				frame_q <= frame_q + 1'b1;
				min_l_q <= nmin_l;
				max_l_q <= nmax_l;
				min_r_q <= nmin_r;
				max_r_q <= nmax_r;
			end
		end
	end

	// stage 1: closed column snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire && emit_now) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit_now) begin
			if (pending_q) begin
				col_s1   <= CW'(eff_w - WW'(1));
				last_s1  <= 1'b1;
				min_l_s1 <= min_l_q;
				max_l_s1 <= max_l_q;
				min_r_s1 <= min_r_q;
				max_r_s1 <= max_r_q;
			end else begin
				col_s1   <= column_q;
				last_s1  <= col_last;
				min_l_s1 <= nmin_l;
				max_l_s1 <= nmax_l;
				min_r_s1 <= nmin_r;
				max_r_s1 <= nmax_r;
			end
		end
	end

	// stage 2: row span per band
	always_comb begin
		if (stereo_q) begin
			top_band = scan_band(min_l_s1, max_l_s1, half_h, half_h, '0);
			bot_band = scan_band(min_r_s1, max_r_s1, half_h, eff_h - half_h, half_h);
		end else begin
			top_band = scan_band(min_l_s1, max_l_s1, eff_h, eff_h, '0);
			bot_band = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (v_s1 && s1_adv) begin
			v_s2 <= 1'b1;
		end else if (out_ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && s1_adv) begin
			col_s2  <= col_s1;
			last_s2 <= last_s1;
			top_s2  <= top_band;
			bot_s2  <= bot_band;
		end
	end

	assign out_valid        = v_s2;
	assign column           = col_s2;
	assign top_first_row    = top_s2.first;
	assign top_last_row     = top_s2.last;
	assign top_lit          = top_s2.lit;
	assign bottom_first_row = bot_s2.first;
	assign bottom_last_row  = bot_s2.last;
	assign bottom_lit       = bot_s2.lit;
	assign last_column      = last_s2;

endmodule

[rtl/wpcr_checker.sv]
module wpcr_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  cfg_ready,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [wpcr_pkg::COL_W-1:0]            column,
	input logic [wpcr_pkg::ROW_W-1:0]            top_first_row,
	input logic [wpcr_pkg::ROW_W-1:0]            top_last_row,
	input logic                                  top_lit,
	input logic [wpcr_pkg::ROW_W-1:0]            bottom_first_row,
	input logic [wpcr_pkg::ROW_W-1:0]            bottom_last_row,
	input logic                                  bottom_lit,
	input logic                                  last_column
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(column) && $stable(last_column)
		&& $stable(top_first_row) && $stable(bottom_last_row))
		else $error("result changed while stalled");

	a_top_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && top_lit |-> top_first_row <= top_last_row)
		else $error("top band span inverted");

	a_bands_apart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && top_lit && bottom_lit |-> bottom_first_row > top_last_row)
		else $error("bottom band overlaps top band");

	a_unlit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bottom_lit |-> bottom_first_row == '0 && bottom_last_row == '0)
		else $error("unlit bottom band carries rows");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> !in_ready)
		else $error("frame taken while column step is recomputed");

endmodule

bind waveform_peak_column_render_core wpcr_checker u_wpcr_checker (.*);

[dv/tb_waveform_peak_column_render_core.sv]
module tb_waveform_peak_column_render_core;

	localparam int unsigned CYCLE_LIMIT   = 2_000_000;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned RANDOM_FRAMES = 1000;
	localparam int unsigned PHASE_CAP     = 160;
	localparam int unsigned REPORT_MAX    = 10;
	localparam int unsigned WIDE_FRAMES   = 300;
	localparam int unsigned LONG_FRAMES   = 400;
	localparam int unsigned LONG_COUNT    = 24'h0BFFFF;

	typedef struct packed {
		logic [wpcr_pkg::COL_W-1:0] column;
		wpcr_pkg::band_t            top;
		wpcr_pkg::band_t            bottom;
		logic                       last;
	} column_peaks_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [wpcr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [wpcr_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	wpcr_pkg::sample_t               sample_left;
	wpcr_pkg::sample_t               sample_right;
	logic                            out_valid;
	logic                            out_ready;
	logic [wpcr_pkg::COL_W-1:0]      column;
	logic [wpcr_pkg::ROW_W-1:0]      top_first_row;
	logic [wpcr_pkg::ROW_W-1:0]      top_last_row;
	logic                            top_lit;
	logic [wpcr_pkg::ROW_W-1:0]      bottom_first_row;
	logic [wpcr_pkg::ROW_W-1:0]      bottom_last_row;
	logic                            bottom_lit;
	logic                            last_column;

	waveform_peak_column_render_core DUT (.*);

	// peak tracker state
	int unsigned p_count, p_width, p_height;
	bit          p_stereo, p_sixteen;
	int unsigned frame_pos, col_pos, col_stop;
	int          left_lo, left_hi, right_lo, right_hi;
	bit          tail_due;

	column_peaks_t column_peaks_q[$];

	bit          calm;
	int unsigned sink_hold_req;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned frames_in;
	int unsigned columns_out;
	int unsigned reg_writes;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int unsigned cols();
		int unsigned w;
		w = p_width;
		if (w < 1) w = 1;
		if (w > wpcr_pkg::MAX_WIDTH) w = wpcr_pkg::MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned span();
		return (p_count < cols()) ? cols() : p_count;
	endfunction

	function automatic int unsigned rows();
		int unsigned h;
		h = p_height;
		if (h < 2) h = 2;
		if (h > wpcr_pkg::MAX_HEIGHT) h = wpcr_pkg::MAX_HEIGHT;
		return h;
	endfunction

	function automatic void find_col_stop();
		longint unsigned prod, e;
		prod = (longint'(col_pos) + 1) * longint'(span());
		e = prod / cols();
		if (e > span() - 1) e = span() - 1;
		col_stop = 32'(e);
	endfunction

	function automatic void restart_pass();
		frame_pos = 0;
		col_pos = 0;
		tail_due = 1'b0;
		left_lo = 32767;
		left_hi = -32768;
		right_lo = 32767;
		right_hi = -32768;
		find_col_stop();
	endfunction

	function automatic void reset_model();
		p_count = wpcr_pkg::RST_SAMPLE_COUNT;
		p_width = wpcr_pkg::RST_WIDTH;
		p_height = wpcr_pkg::RST_HEIGHT;
		p_stereo = 1'b0;
		p_sixteen = 1'b1;
		restart_pass();
	endfunction

	function automatic void apply_reg(input logic [wpcr_pkg::CFG_IDX_W-1:0] idx,
			input logic [wpcr_pkg::CFG_DATA_W-1:0] d);
		case (idx)
		wpcr_pkg::REG_SAMPLE_COUNT: p_count = 32'(d);
		wpcr_pkg::REG_WIDTH:        p_width = 32'(d[wpcr_pkg::WIDTH_W-1:0]);
		wpcr_pkg::REG_HEIGHT:       p_height = 32'(d[wpcr_pkg::HEIGHT_W-1:0]);
		wpcr_pkg::REG_STEREO:       p_stereo = d[0];
		wpcr_pkg::REG_SIXTEEN_BIT:  p_sixteen = d[0];
		default:                    return;
		endcase
		restart_pass();
	endfunction

	function automatic int to_level(input wpcr_pkg::sample_t s);
		if (p_sixteen) return int'(s);
		return int'($signed(s[7:0])) * 256;
	endfunction

	// row k of a band is lit when min*div < (2k-div)*32768 < max*div
	function automatic wpcr_pkg::band_t scan_rows(input int unsigned offset,
			input int unsigned count, input int unsigned div, input int mn, input int mx);
		wpcr_pkg::band_t b;
		longint          lo, hi, lvl;
		logic [31:0]     row;
		b = '0;
		lo = longint'(mn) * longint'(div);
		hi = longint'(mx) * longint'(div);
		for (int unsigned k = 0; k < count; k++) begin
			lvl = (2 * longint'(k) - longint'(div)) * 32768;
			if (lvl > lo && lvl < hi) begin
				row = offset + k;
				if (!b.lit) b.first = row[wpcr_pkg::ROW_W-1:0];
				b.last = row[wpcr_pkg::ROW_W-1:0];
				b.lit = 1'b1;
			end
		end
		return b;
	endfunction

	function automatic column_peaks_t make_peaks(input logic [31:0] col, input bit fin);
		column_peaks_t p;
		int unsigned   h, b;
		h = rows();
		p.column = col[wpcr_pkg::COL_W-1:0];
		if (p_stereo) begin
			b = h / 2;
			p.top = scan_rows(0, b, b, left_lo, left_hi);
			p.bottom = scan_rows(b, h - b, b, right_lo, right_hi);
		end else begin
			p.top = scan_rows(0, h, h, left_lo, left_hi);
			p.bottom = '0;
		end
		p.last = fin;
		return p;
	endfunction

	function automatic bit peak_track_frame(input wpcr_pkg::sample_t sl,
			input wpcr_pkg::sample_t sr, output column_peaks_t res);
		int          l, r;
		int unsigned w;
		bit          got, fin;
		w = cols();
		l = to_level(sl);
		r = to_level(sr);
		got = 1'b0;
		res = '0;
		if (tail_due) begin
			res = make_peaks(w - 1, 1'b1);
			got = 1'b1;
			restart_pass();
		end
		if (l < left_lo) left_lo = l;
		if (l > left_hi) left_hi = l;
		if (r < right_lo) right_lo = r;
		if (r > right_hi) right_hi = r;
		if (!got && frame_pos == col_stop) begin
			fin = (col_pos >= w - 1);
			res = make_peaks(col_pos, fin);
			got = 1'b1;
			if (fin) begin
				restart_pass();
			end else begin
				col_pos = (col_pos + 1) & 32'hFFFF;
				find_col_stop();
				left_lo = l;
				left_hi = l;
				right_lo = r;
				right_hi = r;
				if (col_stop <= frame_pos) tail_due = 1'b1;
				else frame_pos = (frame_pos + 1) & 32'hFFFFFF;
			end
		end else begin
			frame_pos = (frame_pos + 1) & 32'hFFFFFF;
		end
		return got;
	endfunction

	function automatic string show_peaks(input column_peaks_t p);
		return $sformatf("col=%0d top=%0d..%0d lit=%0b bottom=%0d..%0d lit=%0b last=%0b",
			p.column, p.top.first, p.top.last, p.top.lit,
			p.bottom.first, p.bottom.last, p.bottom.lit, p.last);
	endfunction

	always @(posedge clk) begin : scoreboard
		column_peaks_t got, want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				columns_out++;
				got.column = column;
				got.top.first = top_first_row;
				got.top.last = top_last_row;
				got.top.lit = top_lit;
				got.bottom.first = bottom_first_row;
				got.bottom.last = bottom_last_row;
				got.bottom.lit = bottom_lit;
				got.last = last_column;
				if (column_peaks_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected column transfer: %s", show_peaks(got));
				end else begin
					want = column_peaks_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("column mismatch\n  expected %s\n  actual   %s",
								show_peaks(want), show_peaks(got));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				apply_reg(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				frames_in++;
				if (peak_track_frame(sample_left, sample_right, want))
					column_peaks_q.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("stopped at cycle limit with %0d columns outstanding",
				column_peaks_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	initial begin : result_sink
		int unsigned stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_req != 0) begin
				stall = sink_hold_req;
				sink_hold_req = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
			end
		end
	end

	function automatic wpcr_pkg::sample_t pick_sample();
		int          v, div;
		logic [7:0]  junk;
		junk = 8'($urandom);
		case ($urandom_range(0, 11))
		0: return wpcr_pkg::SAMPLE_MAX;
		1: return wpcr_pkg::SAMPLE_MIN;
		2: return '0;
		3: return {junk, 8'h7F};
		4: return {junk, 8'h80};
		5, 6, 7: begin
			// land on or next to a row level
			div = p_stereo ? rows() / 2 : rows();
			v = ((2 * int'($urandom_range(0, 2 * div)) - div) * 32768) / div;
			v = v + int'($urandom_range(0, 2)) - 1;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			if (p_sixteen) return wpcr_pkg::sample_t'(v);
			v = v >>> 8;
			return {junk, v[7:0]};
		end
		default: return wpcr_pkg::sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [wpcr_pkg::CFG_DATA_W-1:0] with_junk(input int unsigned v,
			input int unsigned bits);
		logic [wpcr_pkg::CFG_DATA_W-1:0] d, j;
		d = wpcr_pkg::CFG_DATA_W'(v);
		j = wpcr_pkg::CFG_DATA_W'($urandom);
		if ($urandom_range(0, 3) == 0) d = d | (j << bits);
		return d;
	endfunction

	task automatic send_frame(input wpcr_pkg::sample_t l, input wpcr_pkg::sample_t r);
		int unsigned gap;
		@(negedge clk);
		in_valid <= 1'b1;
		sample_left <= l;
		sample_right <= r;
		do @(posedge clk); while (!in_ready);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [wpcr_pkg::CFG_IDX_W-1:0] idx,
			input logic [wpcr_pkg::CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (column_peaks_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_frame(wpcr_pkg::SAMPLE_MAX, wpcr_pkg::SAMPLE_MIN);
		send_frame(wpcr_pkg::SAMPLE_MIN, wpcr_pkg::SAMPLE_MAX);
		send_frame('0, '0);
		settle();
	endtask

	// width 0, count 0 and height 1 clamp to a one-frame, one-column preview
	task automatic test_register_clamps();
		write_reg(wpcr_pkg::REG_WIDTH, '0);
		write_reg(wpcr_pkg::REG_SAMPLE_COUNT, '0);
		write_reg(wpcr_pkg::REG_HEIGHT, 1);
		send_frame(16'sd100, -16'sd5);
		send_frame(wpcr_pkg::SAMPLE_MIN, wpcr_pkg::SAMPLE_MAX);
		send_frame(wpcr_pkg::SAMPLE_MAX, wpcr_pkg::SAMPLE_MIN);
		settle();
	endtask

	// len == width: last two columns end on one frame, tail reported on the next
	task automatic test_double_close();
		write_reg(wpcr_pkg::REG_WIDTH, 4);
		write_reg(wpcr_pkg::REG_SAMPLE_COUNT, 4);
		write_reg(wpcr_pkg::REG_HEIGHT, 7);
		write_reg(wpcr_pkg::REG_STEREO, 1);
		write_reg(wpcr_pkg::REG_SIXTEEN_BIT, 0);
		send_frame(16'h5A7F, 16'hA580);
		send_frame(16'h0080, 16'hFF7F);
		send_frame(16'h3300, 16'h00C0);
		send_frame(16'hFF40, 16'h1101);
		send_frame(16'h00FF, 16'h8001);
		send_frame(16'h7F80, 16'h807F);
		settle();
	endtask

	// writes to unused indexes must not restart the pass
	task automatic test_ignored_index();
		write_reg(wpcr_pkg::REG_SIXTEEN_BIT, 1);
		write_reg(wpcr_pkg::REG_STEREO, 0);
		write_reg(wpcr_pkg::REG_WIDTH, 2);
		write_reg(wpcr_pkg::REG_SAMPLE_COUNT, 8);
		send_frame(16'sd1000, '0);
		send_frame(-16'sd2000, '0);
		settle();
		for (int i = wpcr_pkg::REG_SIXTEEN_BIT + 1; i < 2 ** wpcr_pkg::CFG_IDX_W; i++)
			write_reg(i[wpcr_pkg::CFG_IDX_W-1:0], wpcr_pkg::CFG_DATA_W'($urandom));
		send_frame(16'sd300, '0);
		send_frame(wpcr_pkg::SAMPLE_MAX, '0);
		send_frame(wpcr_pkg::SAMPLE_MIN, '0);
		settle();
	endtask

	task automatic test_random_columns();
		int unsigned sent, frames, w, ew, n, h, mask;
		sent = 0;
		while (sent < RANDOM_FRAMES) begin
			settle();
			calm = ($urandom_range(0, 4) == 0);
			mask = $urandom_range(1, 31);
			w = p_width;
			if (mask[wpcr_pkg::REG_WIDTH]) begin
				case ($urandom_range(0, 9))
				0:       w = 0;
				1:       w = $urandom_range(13, 64);
				default: w = $urandom_range(1, 12);
				endcase
				write_reg(wpcr_pkg::REG_WIDTH, with_junk(w, wpcr_pkg::WIDTH_W));
			end
			ew = (w < 1) ? 1 : (w > wpcr_pkg::MAX_WIDTH) ? wpcr_pkg::MAX_WIDTH : w;
			if (mask[wpcr_pkg::REG_SAMPLE_COUNT]) begin
				case ($urandom_range(0, 9))
				0, 1:    n = ew;
				2:       n = $urandom_range(0, ew - 1);
				default: n = ew + $urandom_range(0, 3 * ew);
				endcase
				write_reg(wpcr_pkg::REG_SAMPLE_COUNT, wpcr_pkg::CFG_DATA_W'(n));
			end
			if (mask[wpcr_pkg::REG_HEIGHT]) begin
				case ($urandom_range(0, 9))
				0:       h = $urandom_range(0, 1);
				1:       h = $urandom_range(1000, 1024);
				2:       h = $urandom_range(0, 2047);
				default: h = $urandom_range(2, 24);
				endcase
				write_reg(wpcr_pkg::REG_HEIGHT, with_junk(h, wpcr_pkg::HEIGHT_W));
			end
			if (mask[wpcr_pkg::REG_STEREO])
				write_reg(wpcr_pkg::REG_STEREO, with_junk($urandom_range(0, 1), 1));
			if (mask[wpcr_pkg::REG_SIXTEEN_BIT])
				write_reg(wpcr_pkg::REG_SIXTEEN_BIT, with_junk($urandom_range(0, 1), 1));
			frames = span() * $urandom_range(1, 2) + $urandom_range(0, span());
			if (frames > PHASE_CAP) frames = PHASE_CAP;
			repeat (frames) send_frame(pick_sample(), pick_sample());
			sent += frames;
		end
		calm = 1'b0;
		settle();
	endtask

	// output held off while frames keep coming, so the result stages fill
	task automatic test_output_backpressure();
		write_reg(wpcr_pkg::REG_WIDTH, 16);
		write_reg(wpcr_pkg::REG_SAMPLE_COUNT, 16);
		write_reg(wpcr_pkg::REG_HEIGHT, 32);
		write_reg(wpcr_pkg::REG_STEREO, 1);
		write_reg(wpcr_pkg::REG_SIXTEEN_BIT, 1);
		calm = 1'b1;
		sink_hold_req = 300;
		repeat (60) send_frame(pick_sample(), pick_sample());
		calm = 1'b0;
		settle();
	endtask

	// widest and tallest preview, then a long preview with a full-size remainder
	task automatic test_largest_sizes();
		write_reg(wpcr_pkg::REG_WIDTH, wpcr_pkg::CFG_DATA_W'({wpcr_pkg::WIDTH_W{1'b1}}));
		write_reg(wpcr_pkg::REG_SAMPLE_COUNT, '0);
		write_reg(wpcr_pkg::REG_HEIGHT, wpcr_pkg::CFG_DATA_W'({wpcr_pkg::HEIGHT_W{1'b1}}));
		write_reg(wpcr_pkg::REG_STEREO, 1);
		write_reg(wpcr_pkg::REG_SIXTEEN_BIT, 1);
		repeat (WIDE_FRAMES) send_frame(pick_sample(), pick_sample());
		settle();
		write_reg(wpcr_pkg::REG_SAMPLE_COUNT, wpcr_pkg::CFG_DATA_W'(LONG_COUNT));
		write_reg(wpcr_pkg::REG_HEIGHT, 2);
		write_reg(wpcr_pkg::REG_STEREO, 0);
		write_reg(wpcr_pkg::REG_SIXTEEN_BIT, 0);
		repeat (LONG_FRAMES) send_frame(pick_sample(), pick_sample());
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_left = '0;
		sample_right = '0;
		calm = 1'b0;
		sink_hold_req = 0;
		cycle_count = 0;
		mismatches = 0;
		frames_in = 0;
		columns_out = 0;
		reg_writes = 0;
		reset_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_clamps();
		test_double_close();
		test_ignored_index();
		test_random_columns();
		test_output_backpressure();
		test_largest_sizes();
		settle();

		$display("%0d frames, %0d columns checked, %0d register writes, %0d mismatches",
			frames_in, columns_out, reg_writes, mismatches);
		$display("covered clamped registers, double column close, long output stall, widest and tallest preview");
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
